@@ src/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants for the hsv to rgb converter
// Pixel payload structs, fixed-point widths and the hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_BITS   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int CHAN_BITS  = 8;
  localparam int FULL_SCALE = 255;

  // 255 * 2^16, the denominator of the q and t terms
  localparam logic [FRAC_BITS+CHAN_BITS-1:0] DEN =
    (FRAC_BITS+CHAN_BITS)'(FULL_SCALE) << FRAC_BITS;

  typedef struct packed {
    logic [HUE_BITS-1:0]  hue;
    logic [CHAN_BITS-1:0] saturation;
    logic [CHAN_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    SECTOR_RED     = 3'd0,
    SECTOR_YELLOW  = 3'd1,
    SECTOR_GREEN   = 3'd2,
    SECTOR_CYAN    = 3'd3,
    SECTOR_BLUE    = 3'd4,
    SECTOR_MAGENTA = 3'd5
  } sector_t;

endpackage

`default_nettype wire

@@ src/hsv2rgb_div255.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_div255: floor(x / 255) for a 16-bit x no larger than 255 * 255
// Reciprocal estimate x*257 >> 16 is registered, then one compare and
// increment corrects it; the corrected quotient is left combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_div255 (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [2*hsv2rgb_pkg::CHAN_BITS-1:0] x,
  output logic      [hsv2rgb_pkg::CHAN_BITS-1:0]   q
);
  import hsv2rgb_pkg::*;

  localparam int XW = 2 * CHAN_BITS;

  logic [XW+CHAN_BITS:0] prod;
  logic [XW-1:0]         x1;
  logic [CHAN_BITS-1:0]  q0;
  logic [XW-1:0]         q0_scaled;
  logic [XW-1:0]         rem;

  // estimate is never above the true quotient and at most one below
  assign prod = (XW+CHAN_BITS+1)'({x, {CHAN_BITS{1'b0}}}) + (XW+CHAN_BITS+1)'(x);

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      q0 <= prod[XW+CHAN_BITS-1:XW];
    end
  end

  assign q0_scaled = XW'({q0, {CHAN_BITS{1'b0}}}) - XW'(q0);
  assign rem       = x1 - q0_scaled;
  assign q         = q0 + CHAN_BITS'(rem >= XW'(FULL_SCALE));

endmodule

`default_nettype wire

@@ src/hsv_to_rgb_convert.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert: fixed-point hsv to rgb pixel converter
// Five-stage pipeline, one pixel per clock while rgb_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   hsv channel: hsv_valid/hsv_stall/hsv carry hue, saturation, brightness.
//   A transaction completes on a clock edge with valid high and stall low.
//   rgb channel: rgb_valid/rgb_stall/rgb carry red, green, blue, one result
//   per input transaction, in order.
//   Throughput is one pixel per cycle while rgb_stall is low; the stages
//   are hue scaling, the f*s product, the brightness products, the
//   divide-by-255 estimate, and the correction plus channel selection
//   into the output register.
//   Empty stages fill even while the output is stalled, so hsv_stall rises
//   only once every stage holds a pixel and rgb_stall is high.
//   A held result stays unchanged on rgb until it is taken.
//   Synchronous reset empties the pipeline; nothing else holds state.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_convert (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hsv_valid,
  output logic                    hsv_stall,
  input  wire hsv2rgb_pkg::hsv_t  hsv,
  output logic                    rgb_valid,
  input  wire logic               rgb_stall,
  output hsv2rgb_pkg::rgb_t       rgb
);
  import hsv2rgb_pkg::*;

  localparam int H6W = HUE_BITS + 3;
  localparam int NW  = FRAC_BITS + CHAN_BITS;
  localparam int XW  = 2 * CHAN_BITS;

  // stage valids and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5 = !rgb_valid || !rgb_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign hsv_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1) v1 <= hsv_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) rgb_valid <= v4;
    end
  end

  // stage 1: hue times six into sector and fraction, p numerator
  logic [H6W-1:0]                h6;
  logic [HUE_BITS+FRAC_BITS-1:0] frac_wide;
  logic [CHAN_BITS-1:0]          sat_inv;

  assign h6        = H6W'({hsv.hue, 2'b00}) + H6W'({hsv.hue, 1'b0});
  assign frac_wide = {h6[HUE_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign sat_inv   = CHAN_BITS'(FULL_SCALE) - hsv.saturation;

  logic [2:0]           sector1;
  logic [FRAC_BITS-1:0] f1;
  logic [CHAN_BITS-1:0] s1, bv1;
  logic [XW-1:0]        pn1;

  always_ff @(posedge clk) begin
    if (en1) begin
      sector1 <= h6[H6W-1:HUE_BITS];
      f1      <= frac_wide[HUE_BITS+FRAC_BITS-1 -: FRAC_BITS];
      s1      <= hsv.saturation;
      bv1     <= hsv.brightness;
      pn1     <= XW'(hsv.brightness) * XW'(sat_inv);
    end
  end

  // stage 2: q and t numerators
  logic [NW-1:0] fs;
  logic [NW:0]   nt_full;

  assign fs      = NW'(f1) * NW'(s1);
  assign nt_full = (NW+1)'(DEN) - (NW+1)'({s1, {FRAC_BITS{1'b0}}}) + (NW+1)'(fs);

  logic [2:0]           sector2;
  logic [CHAN_BITS-1:0] bv2;
  logic [XW-1:0]        pn2;
  logic [NW-1:0]        nq2, nt2;

  always_ff @(posedge clk) begin
    if (en2) begin
      sector2 <= sector1;
      bv2     <= bv1;
      pn2     <= pn1;
      nq2     <= DEN - fs;
      nt2     <= nt_full[NW-1:0];
    end
  end

  // stage 3: scale by brightness, drop the 2^16 part of the denominator
  logic [NW+CHAN_BITS-1:0] mq, mt;

  assign mq = (NW+CHAN_BITS)'(bv2) * (NW+CHAN_BITS)'(nq2);
  assign mt = (NW+CHAN_BITS)'(bv2) * (NW+CHAN_BITS)'(nt2);

  logic [2:0]           sector3;
  logic [CHAN_BITS-1:0] bv3;
  logic [XW-1:0]        pn3, yq3, yt3;

  always_ff @(posedge clk) begin
    if (en3) begin
      sector3 <= sector2;
      bv3     <= bv2;
      pn3     <= pn2;
      yq3     <= mq[NW+CHAN_BITS-1:FRAC_BITS];
      yt3     <= mt[NW+CHAN_BITS-1:FRAC_BITS];
    end
  end

  // stage 4: divide by 255, estimate registered inside the dividers
  logic [2:0]           sector4;
  logic [CHAN_BITS-1:0] bv4;
  logic [CHAN_BITS-1:0] p, q, t;

  always_ff @(posedge clk) begin
    if (en4) begin
      sector4 <= sector3;
      bv4     <= bv3;
    end
  end

  hsv2rgb_div255 u_div_p (.clk(clk), .en(en4), .x(pn3), .q(p));
  hsv2rgb_div255 u_div_q (.clk(clk), .en(en4), .x(yq3), .q(q));
  hsv2rgb_div255 u_div_t (.clk(clk), .en(en4), .x(yt3), .q(t));

  // stage 5: channel arrangement per sector
  rgb_t rgb_next;

  always_comb begin
    case (sector4)
      SECTOR_RED:    rgb_next = '{red: bv4, green: t,   blue: p};
      SECTOR_YELLOW: rgb_next = '{red: q,   green: bv4, blue: p};
      SECTOR_GREEN:  rgb_next = '{red: p,   green: bv4, blue: t};
      SECTOR_CYAN:   rgb_next = '{red: p,   green: q,   blue: bv4};
      SECTOR_BLUE:   rgb_next = '{red: t,   green: p,   blue: bv4};
      default:       rgb_next = '{red: bv4, green: p,   blue: q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire
